[sv/npcs_pkg.sv]
// shared types and constants of the nearest palette color search unit
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package npcs_pkg;

    localparam int CH_W     = 8;              // one color channel
    localparam int NUM_CH   = 3;              // red, green, blue
    localparam int ENT_W    = CH_W * NUM_CH;  // packed palette entry
    localparam int QCH_W    = 5;              // one channel of a query color
    localparam int QRY_W    = QCH_W * NUM_CH;
    localparam int DIST_W   = 18;             // squared distance
    localparam int IDX_W    = 8;              // reported index
    localparam int DIST_MAX = 195075;         // three channels of 255 squared

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // token handed from cell to cell
    typedef struct packed {
        logic              vld;
        logic              last;
        logic [ENT_W-1:0]  ent;   // channels still to be processed, lowest first
        logic [ENT_W-1:0]  qry;
        logic [DIST_W-1:0] sum;
    } t_tok;

    // status of the minimum tracker
    typedef struct packed {
        logic              done;
        logic [IDX_W-1:0]  idx;
        logic [DIST_W-1:0] dist_sq;
    } t_res;

endpackage

[sv/npcs_cell.sv]
// one distance cell: adds the squared difference of the lowest channel
// and hands the token on with the remaining channels; uses npcs_pkg
`timescale 1ns / 1ps

module npcs_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  npcs_pkg::t_tok i_tok,
    output npcs_pkg::t_tok o_tok
);
    import npcs_pkg::*;

    logic [CH_W-1:0]   w_q;
    logic [CH_W-1:0]   w_e;
    logic [CH_W-1:0]   w_d;
    logic [2*CH_W-1:0] w_sq;
    t_tok              w_nxt;
    logic              r_vld;
    t_tok              r_dat;

    always_comb begin
        w_q  = i_tok.qry[CH_W-1:0];
        w_e  = i_tok.ent[CH_W-1:0];
        w_d  = (w_q > w_e) ? (w_q - w_e) : (w_e - w_q);
        w_sq = w_d * w_d;
        w_nxt      = i_tok;
        w_nxt.ent  = i_tok.ent >> CH_W;
        w_nxt.qry  = i_tok.qry >> CH_W;
        w_nxt.sum  = i_tok.sum + DIST_W'(w_sq);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_tok.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dat <= w_nxt;
    end

    always_comb begin
        o_tok     = r_dat;
        o_tok.vld = r_vld;
    end

endmodule

[sv/npcs_min.sv]
// minimum tracker at the end of the cell chain: keeps the first least
// distance of a scan and its index; uses npcs_pkg
`timescale 1ns / 1ps

module npcs_min #(
    parameter int ENTRIES = 256
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  npcs_pkg::t_tok i_tok,
    input  logic           i_take,
    output npcs_pkg::t_res o_res
);
    import npcs_pkg::*;

    localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    logic [AW-1:0]       r_cnt;
    logic [AW-1:0]       r_best_idx;
    logic [DIST_W-1:0]   r_best;
    logic                r_done;
    logic                w_first;
    logic                w_upd;
    logic [AW+IDX_W-1:0] w_wide;

    assign w_first = (r_cnt == '0);
    assign w_upd   = i_tok.vld && (w_first || (i_tok.sum < r_best));
    assign w_wide  = {{IDX_W{1'b0}}, r_best_idx};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            if (i_tok.vld) begin
                r_cnt <= i_tok.last ? '0 : r_cnt + AW'(1);
            end
            if (i_tok.vld && i_tok.last) begin
                r_done <= 1'b1;
            end else if (i_take) begin
                r_done <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_upd) begin
            r_best     <= i_tok.sum;
            r_best_idx <= r_cnt;
        end
    end

    always_comb begin
        o_res.done    = r_done;
        o_res.idx     = w_wide[IDX_W-1:0];
        o_res.dist_sq = r_best;
    end

`ifndef ASSERT_OFF
    a_first_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_tok.vld && w_first |=> r_best == $past(i_tok.sum))
        else $error("first entry of a scan not taken as best");
    a_dist_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> r_best <= DIST_W'(DIST_MAX))
        else $error("best distance out of range");
`endif

endmodule

[sv/nearest_palette_color_search_unit.sv]
// top level of the nearest palette color search unit: palette memory,
// scan sequencer, chain of distance cells and output register
// depends on npcs_pkg, npcs_cell and npcs_min
`timescale 1ns / 1ps

// usage
//   input channel (s_axis): tuser carries the opcode, tdata the payload.
//   a write request stores red, green and blue into one palette entry;
//   writes to the last entry (transparent black) and to indexes beyond
//   the palette are dropped and give no result.
//   a query request expands its 15-bit color to 8 bits per channel and
//   scans every entry, one memory read per cycle, through a chain of three
//   distance cells (one channel each) and a minimum tracker.
//   output channel (m_axis): one result per query, the index of the first
//   nearest entry and its squared distance.
// queries
//   a query's result follows the one-read-per-cycle scan of every entry;
//   the input is not ready until the result is loaded, so a query is
//   only accepted once the previous one is through
// reset: the palette memory is cleared to black after i_rst_n is released,
//   one entry a cycle, with tready low meanwhile
// stall
//   a result waits in the output register until taken; new requests are
//   accepted meanwhile, and a finished scan holds in the tracker until the
//   output register is free.

module nearest_palette_color_search_unit #(
    parameter int PALETTE_ENTRIES = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // entry_index[7:0], red[15:8], green[23:16], blue[31:24],
    // query_color[46:32], zero[47]
    input  logic [47:0] i_s_axis_tdata,
    // opcode[0]
    input  logic        i_s_axis_tuser,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // best_index[7:0], best_distance_sq[25:8], zero[31:26]
    output logic [31:0] o_m_axis_tdata
);
    import npcs_pkg::*;

    localparam int AW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;

    localparam logic [1:0] ST_CLR   = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_SCAN  = 2'd2;
    localparam logic [1:0] ST_DRAIN = 2'd3;

    // request fields
    logic [IDX_W-1:0]    w_in_idx;
    logic [CH_W-1:0]     w_in_red;
    logic [CH_W-1:0]     w_in_green;
    logic [CH_W-1:0]     w_in_blue;
    logic [QRY_W-1:0]    w_in_qry;
    logic                w_acc;
    logic [AW+IDX_W-1:0] w_idx_wide;
    logic                w_idx_ok;

    // sequencer
    logic [1:0]          r_state;
    logic [1:0]          n_state;
    logic [AW-1:0]       r_addr;
    logic [AW-1:0]       n_addr;
    logic [ENT_W-1:0]    r_qry;
    logic                w_addr_end;

    // palette memory
    logic [ENT_W-1:0]    r_mem [PALETTE_ENTRIES];
    logic                w_we;
    logic [AW-1:0]       w_waddr;
    logic [ENT_W-1:0]    w_wdata;
    logic [ENT_W-1:0]    r_rd;
    logic                r_iss_vld;
    logic                r_iss_last;

    // cell chain and tracker
    t_tok                w_tok [NUM_CH+1];
    t_res                w_res;
    logic                w_take;

    // output register
    logic                r_out_vld;
    logic [IDX_W-1:0]    r_out_idx;
    logic [DIST_W-1:0]   r_out_dist;

    assign w_in_idx   = i_s_axis_tdata[7:0];
    assign w_in_red   = i_s_axis_tdata[15:8];
    assign w_in_green = i_s_axis_tdata[23:16];
    assign w_in_blue  = i_s_axis_tdata[31:24];
    assign w_in_qry   = i_s_axis_tdata[46:32];

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign w_acc           = i_s_axis_tvalid && o_s_axis_tready;

    // the last entry is transparent and never written by a request
    assign w_idx_wide = {{AW{1'b0}}, w_in_idx};
    assign w_idx_ok   = w_idx_wide < (AW+IDX_W)'(PALETTE_ENTRIES - 1);
    assign w_addr_end = (r_addr == AW'(PALETTE_ENTRIES - 1));

    always_comb begin
        n_state = r_state;
        n_addr  = r_addr;
        case (r_state)
            ST_CLR: begin
                n_addr = r_addr + AW'(1);
                if (w_addr_end) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                n_addr = '0;
                if (w_acc && (i_s_axis_tuser == OP_QUERY)) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                n_addr = r_addr + AW'(1);
                if (w_addr_end) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (w_take) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLR;
            r_addr     <= '0;
            r_iss_vld  <= 1'b0;
            r_iss_last <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_addr     <= n_addr;
            r_iss_vld  <= (r_state == ST_SCAN);
            r_iss_last <= (r_state == ST_SCAN) && w_addr_end;
        end
    end

    // query color expanded as (c << 3) + 4 per channel, red lowest
    always_ff @(posedge i_clk) begin
        if (w_acc && (i_s_axis_tuser == OP_QUERY)) begin
            r_qry <= {w_in_qry[14:10], 3'b100, w_in_qry[9:5], 3'b100,
                      w_in_qry[4:0], 3'b100};
        end
    end

    // single write port shared by the clearing sweep and write requests
    assign w_we    = (r_state == ST_CLR) ||
                     (w_acc && (i_s_axis_tuser == OP_WRITE) && w_idx_ok);
    assign w_waddr = (r_state == ST_CLR) ? r_addr : w_idx_wide[AW-1:0];
    assign w_wdata = (r_state == ST_CLR) ? '0 : {w_in_blue, w_in_green, w_in_red};

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rd <= r_mem[r_addr];
    end

    // head token of the chain
    always_comb begin
        w_tok[0].vld  = r_iss_vld;
        w_tok[0].last = r_iss_last;
        w_tok[0].ent  = r_rd;
        w_tok[0].qry  = r_qry;
        w_tok[0].sum  = '0;
    end

    for (genvar g = 0; g < NUM_CH; g++) begin : g_cell
        npcs_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_tok   (w_tok[g]),
            .o_tok   (w_tok[g+1])
        );
    end

    npcs_min #(
        .ENTRIES (PALETTE_ENTRIES)
    ) u_min (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tok   (w_tok[NUM_CH]),
        .i_take  (w_take),
        .o_res   (w_res)
    );

    assign w_take = (r_state == ST_DRAIN) && w_res.done &&
                    (!r_out_vld || i_m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_take) begin
            r_out_vld <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_out_idx  <= w_res.idx;
            r_out_dist <= w_res.dist_sq;
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = {6'b0, r_out_dist, r_out_idx};

`ifndef ASSERT_OFF
    a_clr_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_CLR |-> !o_s_axis_tready)
        else $error("request accepted during clearing sweep");
    a_take_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take |=> r_state == ST_IDLE && r_out_vld)
        else $error("result load without return to idle");
    a_scan_ends_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_iss_vld) |-> $past(r_iss_last))
        else $error("scan ended without last token");
`endif

endmodule

[sim/testbench.sv]
// self-checking testbench of the nearest palette color search unit
// drives palette writes and color queries, predicts each match and compares it
// depends on npcs_pkg and nearest_palette_color_search_unit
`timescale 1ns / 1ps

module testbench;
    import npcs_pkg::*;

    localparam int PALETTE_ENTRIES = 256;
    localparam int CLK_HALF        = 6;
    localparam int RANDOM_ITEMS    = 900;
    // room for every request with a full scan, the longest input gap and the longest output stall
    localparam int CYCLE_LIMIT     = 1_500_000;
    // longer than a query's full scan, so any stray result shows up by then
    localparam int DRAIN_CYCLES    = PALETTE_ENTRIES + 16;

    // one request on the input stream
    typedef struct {
        logic             opcode;
        logic [7:0]       entry_index;
        logic [CH_W-1:0]  red;
        logic [CH_W-1:0]  green;
        logic [CH_W-1:0]  blue;
        logic [QRY_W-1:0] query_color;
    } t_palette_req;

    // one result on the output stream
    typedef struct {
        logic [IDX_W-1:0]  best_index;
        logic [DIST_W-1:0] distance_sq;
    } t_color_match;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    // entry_index[7:0], red[15:8], green[23:16], blue[31:24], query_color[46:32], zero[47]
    logic [47:0] s_tdata  = '0;
    // opcode[0]
    logic        s_tuser  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // best_index[7:0], best_distance_sq[25:8], zero[31:26]
    logic [31:0] m_tdata;

    // stimulus waiting for the driver, and matches waiting for the output stream
    t_palette_req pending_requests[$];
    t_color_match expected_matches[$];

    // predictor's own copy of the palette, blue/green/red from the top byte down
    logic [ENT_W-1:0] palette_model [PALETTE_ENTRIES] = '{default: '0};

    // colors written lately, reused by the generator to force ties and near hits
    logic [ENT_W-1:0] recent_colors[$];

    t_palette_req active_request;
    t_color_match want_match;
    t_color_match got_match;

    int unsigned total_requests  = 0;
    int unsigned accepted_count  = 0;
    int unsigned write_count     = 0;
    int unsigned dropped_writes  = 0;
    int unsigned query_count     = 0;
    int unsigned matches_checked = 0;
    int unsigned error_count     = 0;
    int unsigned cycle_count     = 0;

    // idle bookkeeping of both stream sides
    int unsigned send_gap   = 0;
    int unsigned send_calm  = 0;
    int unsigned stall_left = 0;
    int unsigned recv_calm  = 0;

    always #CLK_HALF clk = ~clk;

    nearest_palette_color_search_unit #(
        .PALETTE_ENTRIES(PALETTE_ENTRIES)
    ) i_dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_s_axis_tvalid(s_tvalid),
        .o_s_axis_tready(s_tready),
        .i_s_axis_tdata (s_tdata),
        .i_s_axis_tuser (s_tuser),
        .o_m_axis_tvalid(m_tvalid),
        .i_m_axis_tready(m_tready),
        .o_m_axis_tdata (m_tdata)
    );

    // exhaustive scan over the model palette, strictly smaller distance wins,
    // so the lowest index is kept on ties; entry 0 always becomes the first best
    function automatic t_color_match nearest_entry_search(logic [QRY_W-1:0] color);
        t_color_match best;
        int unsigned  target [NUM_CH];
        int unsigned  best_sq;
        int unsigned  sum_sq;
        int unsigned  level;
        int unsigned  delta;
        best_sq          = 32'hFFFF_FFFF;
        best.best_index  = '0;
        best.distance_sq = '0;
        // 5-bit channel to 8 bits: shift up and center in the step
        for (int c = 0; c < NUM_CH; c++) begin
            target[c] = (int'(color[c*QCH_W +: QCH_W]) << 3) + 4;
        end
        for (int k = 0; k < PALETTE_ENTRIES; k++) begin
            sum_sq = 0;
            for (int c = 0; c < NUM_CH; c++) begin
                level  = 32'(palette_model[k][c*CH_W +: CH_W]);
                delta  = (target[c] > level) ? target[c] - level : level - target[c];
                sum_sq += delta * delta;
            end
            if (sum_sq < best_sq) begin
                best_sq          = sum_sq;
                best.best_index  = IDX_W'(k);
                best.distance_sq = DIST_W'(sum_sq);
            end
        end
        return best;
    endfunction

    // update the model for one accepted request
    function automatic void apply_request(t_palette_req req);
        if (req.opcode == OP_WRITE) begin
            write_count++;
            // transparent last entry and anything past the store stay untouched
            if (req.entry_index < PALETTE_ENTRIES - 1)
                palette_model[req.entry_index] = {req.blue, req.green, req.red};
            else
                dropped_writes++;
        end else begin
            query_count++;
            expected_matches.push_back(nearest_entry_search(req.query_color));
        end
    endfunction

    function automatic int unsigned rgb555(int unsigned r, int unsigned g, int unsigned b);
        return (r & 5'h1F) | ((g & 5'h1F) << 5) | ((b & 5'h1F) << 10);
    endfunction

    // unused fields of both kinds get random content, the block must ignore it
    function automatic t_palette_req write_req(int unsigned idx, int unsigned r,
                                               int unsigned g, int unsigned b);
        t_palette_req req;
        req.opcode      = OP_WRITE;
        req.entry_index = 8'(idx);
        req.red         = CH_W'(r);
        req.green       = CH_W'(g);
        req.blue        = CH_W'(b);
        req.query_color = QRY_W'($urandom);
        return req;
    endfunction

    function automatic t_palette_req query_req(int unsigned color);
        t_palette_req req;
        req.opcode      = OP_QUERY;
        req.entry_index = 8'($urandom);
        req.red         = CH_W'($urandom);
        req.green       = CH_W'($urandom);
        req.blue        = CH_W'($urandom);
        req.query_color = QRY_W'(color);
        return req;
    endfunction

    function automatic t_palette_req random_request();
        t_palette_req     req;
        logic [ENT_W-1:0] rgb;
        logic [QRY_W-1:0] color;
        int unsigned      pick;
        if ($urandom_range(99) < 55) begin
            // writes: mostly anywhere, with the last live entry, the transparent
            // one and entry 0 favored
            pick = $urandom_range(9);
            req  = write_req(pick < 7 ? $urandom_range(255) : pick == 7 ? 254 :
                             pick == 8 ? 255 : 0, 0, 0, 0);
            pick = $urandom_range(3);
            if (pick == 0 && recent_colors.size() != 0) begin
                // duplicate color, gives equal distances at several indexes
                rgb = recent_colors[$urandom_range(recent_colors.size() - 1)];
            end else if (pick == 1) begin
                for (int c = 0; c < NUM_CH; c++)
                    rgb[c*CH_W +: CH_W] = $urandom_range(1) ? 8'hFF : 8'h00;
            end else begin
                rgb = ENT_W'($urandom);
            end
            {req.blue, req.green, req.red} = rgb;
            recent_colors.push_back(rgb);
            if (recent_colors.size() > 16)
                void'(recent_colors.pop_front());
        end else begin
            pick = $urandom_range(9);
            if (pick < 4 || recent_colors.size() == 0) begin
                color = QRY_W'($urandom);
            end else if (pick < 8) begin
                // aim at a stored color: top five bits of each channel
                rgb = recent_colors[$urandom_range(recent_colors.size() - 1)];
                for (int c = 0; c < NUM_CH; c++)
                    color[c*QCH_W +: QCH_W] = rgb[c*CH_W + 3 +: QCH_W];
            end else begin
                for (int c = 0; c < NUM_CH; c++)
                    color[c*QCH_W +: QCH_W] = $urandom_range(1) ? 5'h1F : 5'h00;
            end
            req = query_req(32'(color));
        end
        return req;
    endfunction

    // mostly back to back, some short gaps, a few long ones
    function automatic int unsigned random_delay();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 70)
            return 0;
        if (roll < 94)
            return $urandom_range(3, 1);
        return $urandom_range(48, 8);
    endfunction

    // request driver: holds each request until accepted, then idles for a random gap
    always @(posedge clk) begin
        if (!rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                apply_request(active_request);
                accepted_count++;
            end
            if (!s_tvalid || s_tready) begin
                if (send_gap != 0) begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end else if (pending_requests.size() != 0) begin
                    active_request = pending_requests.pop_front();
                    s_tdata  <= {1'b0, active_request.query_color, active_request.blue,
                                 active_request.green, active_request.red,
                                 active_request.entry_index};
                    s_tuser  <= active_request.opcode;
                    s_tvalid <= 1'b1;
                    // stretches of requests with no idling in between
                    if (send_calm != 0) begin
                        send_calm--;
                        send_gap = 0;
                    end else begin
                        send_gap = random_delay();
                        if ($urandom_range(49) == 0)
                            send_calm = $urandom_range(60, 20);
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor: random back pressure, every taken result checked against
    // the oldest prediction
    always @(posedge clk) begin
        if (!rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got_match.best_index  = m_tdata[7:0];
                got_match.distance_sq = m_tdata[25:8];
                matches_checked++;
                if (expected_matches.size() == 0) begin
                    error_count++;
                    $display("%0t: result with no query pending: expected none, got index %0d distance %0d",
                             $time, got_match.best_index, got_match.distance_sq);
                end else begin
                    want_match = expected_matches.pop_front();
                    if (got_match.best_index !== want_match.best_index) begin
                        error_count++;
                        $display("%0t: best_index mismatch: expected %0d, got %0d",
                                 $time, want_match.best_index, got_match.best_index);
                    end
                    if (got_match.distance_sq !== want_match.distance_sq) begin
                        error_count++;
                        $display("%0t: best_distance_sq mismatch: expected %0d, got %0d",
                                 $time, want_match.distance_sq, got_match.distance_sq);
                    end
                end
            end
            if (stall_left != 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if (recv_calm != 0) begin
                    recv_calm--;
                end else begin
                    if ($urandom_range(3) == 0)
                        stall_left = random_delay();
                    if ($urandom_range(199) == 0)
                        recv_calm = $urandom_range(2000, 200);
                end
            end
        end
    end

    // watchdog
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d matches still pending",
                 cycle_count, expected_matches.size());
        $display("Test completed with failures");
        $finish;
    end

    // stimulus and end of run
    initial begin
        t_palette_req req;
        int unsigned  useful;

        // black palette after reset: the nearest is entry 0 at both color extremes
        pending_requests.push_back(query_req(0));
        pending_requests.push_back(query_req(32'h7FFF));
        // transparent entry cannot be written, query must still pick entry 0
        pending_requests.push_back(write_req(255, 255, 255, 255));
        pending_requests.push_back(query_req(32'h7FFF));
        // white at entry 0, exact hit for full-scale query at the last live entry
        pending_requests.push_back(write_req(0, 255, 255, 255));
        pending_requests.push_back(write_req(254, 252, 252, 252));
        pending_requests.push_back(query_req(32'h7FFF));
        pending_requests.push_back(query_req(0));
        // equal colors at two entries, the lower index wins
        pending_requests.push_back(write_req(10, 100, 100, 100));
        pending_requests.push_back(write_req(20, 100, 100, 100));
        pending_requests.push_back(query_req(rgb555(12, 12, 12)));
        // each channel alone
        pending_requests.push_back(write_req(5, 255, 0, 0));
        pending_requests.push_back(write_req(6, 0, 255, 0));
        pending_requests.push_back(write_req(7, 0, 0, 255));
        pending_requests.push_back(query_req(rgb555(31, 0, 0)));
        pending_requests.push_back(query_req(rgb555(0, 31, 0)));
        pending_requests.push_back(query_req(rgb555(0, 0, 31)));
        // unused fields all ones must not leak into either operation
        req = write_req(3, 1, 2, 3);
        req.query_color = '1;
        pending_requests.push_back(req);
        req = query_req(rgb555(0, 0, 0));
        req.entry_index = '1;
        req.red         = '1;
        req.green       = '1;
        req.blue        = '1;
        pending_requests.push_back(req);
        pending_requests.push_back(query_req(rgb555(1, 0, 0)));

        // random part; writes to the transparent entry do not count
        useful = 0;
        while (useful < RANDOM_ITEMS) begin
            req = random_request();
            pending_requests.push_back(req);
            if (!(req.opcode == OP_WRITE && req.entry_index == PALETTE_ENTRIES - 1))
                useful++;
        end
        total_requests = pending_requests.size();

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // the palette clear after reset is covered by waiting on the handshake
        while (accepted_count < total_requests || expected_matches.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d requests sent: %0d palette writes (%0d dropped), %0d queries",
                 accepted_count, write_count, dropped_writes, query_count);
        $display("%0d matches checked, %0d errors, %0d cycles",
                 matches_checked, error_count, cycle_count);
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
